>>> design/htdu_pkg.sv
// Package for the handheld timer/divider unit: opcode and register codes,
// field widths and the prescale period lookup. Depends on nothing.

package htdu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CtrlW     = 3;
  localparam int unsigned PrescaleW = 11;

  localparam logic [PrescaleW-1:0] PrescaleMax = '1;
  localparam logic [ByteW-1:0]     ByteMax     = '1;

  // Control register bit holding the counter enable
  localparam int unsigned CtrlEnableBit = 2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_DIVIDER = 2'd0,
    REG_COUNTER = 2'd1,
    REG_MODULO  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    PER_1024 = 2'd0,
    PER_16   = 2'd1,
    PER_64   = 2'd2,
    PER_256  = 2'd3
  } period_sel_e;

  // Prescale period selected by control bits 1..0
  function automatic logic [PrescaleW-1:0] period_of(input logic [1:0] sel);
    logic [PrescaleW-1:0] per;
    unique case (period_sel_e'(sel))
      PER_1024: per = PrescaleW'(1024);
      PER_16:   per = PrescaleW'(16);
      PER_64:   per = PrescaleW'(64);
      PER_256:  per = PrescaleW'(256);
      default:  per = PrescaleW'(1024);
    endcase
    return per;
  endfunction

endpackage

>>> design/handheld_timer_divider_unit.sv
// Top level of the handheld timer/divider unit: input register, register
// file with tick logic, and result register. Depends on htdu_pkg.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   a register read, a register write, or a tick of elapsed machine cycles.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   command: read_data_o holds the selected register on a read and zero
//   otherwise; timer_irq_o pulses on the tick whose counter overflow reloaded
//   the counter from the modulo register.
//   Flow: a command taken is held in the input register; its effect on the
//   registers and its result are committed together when it moves on into
//   the result register, which offers the result on the output channel.
//   Throughput: one command per cycle while the receiver does not stall.
//   The whole decode, the 11-bit prescale add, saturate, compare and
//   subtract and the 8-bit counter step sit in one combinational pass
//   between the input register and the result register.
//   Stalls: while the receiver stalls a waiting result, the result register
//   holds and one further command waits in the input register; only then is
//   in_stall_o raised. No state changes while a command waits.
//   Reset: all timer registers, the prescale count and both valid flags
//   clear; the control register reads as period 1024, timer disabled.

module handheld_timer_divider_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [1:0]                   reg_select_i,
  input  logic [htdu_pkg::ByteW-1:0]   write_data_i,
  input  logic [htdu_pkg::ByteW-1:0]   elapsed_cycles_i,
  input  logic                         divider_step_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [htdu_pkg::ByteW-1:0]   read_data_o,
  output logic                         timer_irq_o
);

  // Input register
  logic                       in_valid_q;
  logic [1:0]                 opcode_q;
  logic [1:0]                 reg_select_q;
  logic [htdu_pkg::ByteW-1:0] write_data_q;
  logic [htdu_pkg::ByteW-1:0] elapsed_cycles_q;
  logic                       divider_step_q;

  // Timer state
  logic [htdu_pkg::ByteW-1:0]     divider_q, divider_d;
  logic [htdu_pkg::ByteW-1:0]     counter_q, counter_d;
  logic [htdu_pkg::ByteW-1:0]     modulo_q, modulo_d;
  logic [htdu_pkg::CtrlW-1:0]     control_q, control_d;
  logic [htdu_pkg::PrescaleW-1:0] prescale_q, prescale_d;

  // Result register
  logic                       out_valid_q;
  logic [htdu_pkg::ByteW-1:0] read_data_q, read_data_d;
  logic                       timer_irq_q, timer_irq_d;

  logic out_free;
  logic in_accept;
  logic commit;

  // The result register takes a new entry when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Capture the command; hold it while the result side is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (commit) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      opcode_q         <= opcode_i;
      reg_select_q     <= reg_select_i;
      write_data_q     <= write_data_i;
      elapsed_cycles_q <= elapsed_cycles_i;
      divider_step_q   <= divider_step_i;
    end
  end

  // Single pass: decode the held command, compute next state and result
  always_comb begin
    logic [htdu_pkg::PrescaleW:0]   sum;
    logic [htdu_pkg::PrescaleW-1:0] sat;
    logic [htdu_pkg::PrescaleW-1:0] per;

    divider_d   = divider_q;
    counter_d   = counter_q;
    modulo_d    = modulo_q;
    control_d   = control_q;
    prescale_d  = prescale_q;
    read_data_d = '0;
    timer_irq_d = 1'b0;

    sum = {1'b0, prescale_q} + (htdu_pkg::PrescaleW+1)'(elapsed_cycles_q);
    sat = sum[htdu_pkg::PrescaleW] ? htdu_pkg::PrescaleMax : sum[htdu_pkg::PrescaleW-1:0];
    per = htdu_pkg::period_of(control_q[1:0]);

    unique case (htdu_pkg::opcode_e'(opcode_q))
      htdu_pkg::OP_READ: begin
        unique case (htdu_pkg::reg_sel_e'(reg_select_q))
          htdu_pkg::REG_DIVIDER: read_data_d = divider_q;
          htdu_pkg::REG_COUNTER: read_data_d = counter_q;
          htdu_pkg::REG_MODULO:  read_data_d = modulo_q;
          default:               read_data_d = htdu_pkg::ByteW'(control_q);
        endcase
      end
      htdu_pkg::OP_WRITE: begin
        unique case (htdu_pkg::reg_sel_e'(reg_select_q))
          htdu_pkg::REG_DIVIDER: divider_d = '0;
          htdu_pkg::REG_COUNTER: counter_d = write_data_q;
          htdu_pkg::REG_MODULO:  modulo_d  = write_data_q;
          default: begin
            // Keep the low control bits and restart the prescaler
            control_d  = write_data_q[htdu_pkg::CtrlW-1:0];
            prescale_d = '0;
          end
        endcase
      end
      htdu_pkg::OP_TICK: begin
        if (divider_step_q) begin
          divider_d = divider_q + 1'b1;
        end
        prescale_d = sat;
        // At most one period per tick
        if (sat >= per) begin
          prescale_d = sat - per;
          if (control_q[htdu_pkg::CtrlEnableBit]) begin
            if (counter_q == htdu_pkg::ByteMax) begin
              counter_d   = modulo_q;
              timer_irq_d = 1'b1;
            end else begin
              counter_d = counter_q + 1'b1;
            end
          end
        end
      end
      default: ;  // unused opcode: no effect, all-zero result
    endcase
  end

  // Commit state only when the command moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q  <= '0;
      counter_q  <= '0;
      modulo_q   <= '0;
      control_q  <= '0;
      prescale_q <= '0;
    end else if (commit) begin
      divider_q  <= divider_d;
      counter_q  <= counter_d;
      modulo_q   <= modulo_d;
      control_q  <= control_d;
      prescale_q <= prescale_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      read_data_q <= read_data_d;
      timer_irq_q <= timer_irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign timer_irq_o = timer_irq_q;

`ifndef SYNTHESIS
  // Stall only when both stages are occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled without a full pipeline");

  // A committed command always lands in the result register
  a_commit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed command lost");

  // An interrupt reloads the counter from modulo
  a_irq_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && timer_irq_d) |=> (counter_q == $past(modulo_q)))
    else $error("overflow did not reload the counter");

  // A control write restarts the prescaler
  a_ctrl_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (opcode_q == htdu_pkg::OP_WRITE) && (reg_select_q == htdu_pkg::REG_CONTROL))
    |=> (prescale_q == '0))
    else $error("control write did not clear the prescale count");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for handheld_timer_divider_unit: directed and random
// register reads, writes and ticks against a cycle-free model of the timer.
// Depends on htdu_pkg and the unit's top level only.

module tb_top;

  // Opcode three has no package name; the unit must answer it with zeros
  localparam logic [1:0]  OpNop        = 2'd3;
  localparam int unsigned RandomItems  = 1300;
  localparam int unsigned PhaseLen     = 100;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [htdu_pkg::ByteW-1:0] read_data;
    logic                       timer_irq;
  } timer_result_t;

  // Shadow copy of the timer registers plus the queue of results still owed
  class timer_scoreboard;
    logic [htdu_pkg::ByteW-1:0]     divider;
    logic [htdu_pkg::ByteW-1:0]     counter;
    logic [htdu_pkg::ByteW-1:0]     modulo;
    logic [htdu_pkg::CtrlW-1:0]     control;
    logic [htdu_pkg::PrescaleW-1:0] prescale;
    timer_result_t                  owed_results[$];
    int unsigned                    errors;
    int unsigned                    commands;
    int unsigned                    ticks;
    int unsigned                    irqs;

    function new();
      divider  = '0;
      counter  = '0;
      modulo   = '0;
      control  = '0;
      prescale = '0;
      errors   = 0;
      commands = 0;
      ticks    = 0;
      irqs     = 0;
    endfunction

    function automatic int unsigned period_len(logic [1:0] sel);
      case (htdu_pkg::period_sel_e'(sel))
        htdu_pkg::PER_16:  return 16;
        htdu_pkg::PER_64:  return 64;
        htdu_pkg::PER_256: return 256;
        default:           return 1024;
      endcase
    endfunction

    // Apply one accepted command to the shadow state and queue its result
    function automatic void take_command(logic [1:0] op, logic [1:0] sel,
                                         logic [htdu_pkg::ByteW-1:0] data,
                                         logic [htdu_pkg::ByteW-1:0] cycles,
                                         logic step);
      timer_result_t res;
      int unsigned   sum;
      res      = '0;
      commands = commands + 1;
      case (op)
        htdu_pkg::OP_READ: begin
          case (htdu_pkg::reg_sel_e'(sel))
            htdu_pkg::REG_DIVIDER: res.read_data = divider;
            htdu_pkg::REG_COUNTER: res.read_data = counter;
            htdu_pkg::REG_MODULO:  res.read_data = modulo;
            default: res.read_data = {{(htdu_pkg::ByteW-htdu_pkg::CtrlW){1'b0}}, control};
          endcase
        end
        htdu_pkg::OP_WRITE: begin
          case (htdu_pkg::reg_sel_e'(sel))
            htdu_pkg::REG_DIVIDER: divider = '0;
            htdu_pkg::REG_COUNTER: counter = data;
            htdu_pkg::REG_MODULO:  modulo  = data;
            default: begin
              control  = data[htdu_pkg::CtrlW-1:0];
              prescale = '0;
            end
          endcase
        end
        htdu_pkg::OP_TICK: begin
          ticks = ticks + 1;
          if (step) divider = divider + 1'b1;
          sum = int'(prescale) + int'(cycles);
          if (sum > int'(htdu_pkg::PrescaleMax)) sum = int'(htdu_pkg::PrescaleMax);
          if (sum >= period_len(control[1:0])) begin
            sum = sum - period_len(control[1:0]);
            if (control[htdu_pkg::CtrlEnableBit]) begin
              if (counter == htdu_pkg::ByteMax) begin
                counter       = modulo;
                res.timer_irq = 1'b1;
                irqs          = irqs + 1;
              end else begin
                counter = counter + 1'b1;
              end
            end
          end
          prescale = htdu_pkg::PrescaleW'(sum);
        end
        default: ;
      endcase
      owed_results.push_back(res);
    endfunction

    function automatic void check_result(logic [htdu_pkg::ByteW-1:0] rd, logic irq);
      timer_result_t exp_res;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, read_data %02h timer_irq %0b",
                 $time, rd, irq);
        errors = errors + 1;
        return;
      end
      exp_res = owed_results.pop_front();
      if (rd !== exp_res.read_data) begin
        $display("%0t: read_data mismatch, expected %02h, actual %02h",
                 $time, exp_res.read_data, rd);
        errors = errors + 1;
      end
      if (irq !== exp_res.timer_irq) begin
        $display("%0t: timer_irq mismatch, expected %0b, actual %0b",
                 $time, exp_res.timer_irq, irq);
        errors = errors + 1;
      end
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [1:0]                 opcode_i;
  logic [1:0]                 reg_select_i;
  logic [htdu_pkg::ByteW-1:0] write_data_i;
  logic [htdu_pkg::ByteW-1:0] elapsed_cycles_i;
  logic                       divider_step_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [htdu_pkg::ByteW-1:0] read_data_o;
  logic                       timer_irq_o;

  timer_scoreboard scoreboard_h;
  int unsigned     idle_cycles;
  bit              src_gaps_en;
  bit              sink_stalls_en;

  handheld_timer_divider_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .reg_select_i    (reg_select_i),
    .write_data_i    (write_data_i),
    .elapsed_cycles_i(elapsed_cycles_i),
    .divider_step_i  (divider_step_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .timer_irq_o     (timer_irq_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly back-to-back, now and then a short pause, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample both channels at the rising edge. Check the outgoing transfer
  // before noting the incoming one; a command passes the input register first,
  // so they never belong to the same command. Any transfer clears the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        scoreboard_h.check_result(read_data_o, timer_irq_o);
      if (in_valid_i && !in_stall_o)
        scoreboard_h.take_command(opcode_i, reg_select_i, write_data_i,
                                  elapsed_cycles_i, divider_step_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long
  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("Verification failed");
    $finish;
  end

  // Receiver: alternate free runs with stall bursts; bursts vanish while
  // sink_stalls_en is clear so whole phases run without back-pressure
  initial begin
    int unsigned free_len;
    int unsigned busy_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      free_len = $urandom_range(1, 6);
      busy_len = sink_stalls_en ? pick_gap() : 0;
      repeat (free_len) @(negedge clk_i) out_stall_i <= 1'b0;
      repeat (busy_len) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  // Offer one command at the falling edge and hold it until it is taken.
  // Junk payload is driven during a gap so that valid alone qualifies it.
  task automatic send_cmd(input logic [1:0] op, input logic [1:0] sel,
                          input logic [htdu_pkg::ByteW-1:0] data,
                          input logic [htdu_pkg::ByteW-1:0] cycles,
                          input logic step);
    int unsigned gap;
    gap = src_gaps_en ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i       <= 1'b0;
      opcode_i         <= 2'($urandom);
      reg_select_i     <= 2'($urandom);
      write_data_i     <= htdu_pkg::ByteW'($urandom);
      elapsed_cycles_i <= htdu_pkg::ByteW'($urandom);
      divider_step_i   <= 1'($urandom);
    end
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    reg_select_i     <= sel;
    write_data_i     <= data;
    elapsed_cycles_i <= cycles;
    divider_step_i   <= step;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic read_reg(input htdu_pkg::reg_sel_e sel);
    send_cmd(htdu_pkg::OP_READ, sel, htdu_pkg::ByteW'($urandom),
             htdu_pkg::ByteW'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(input htdu_pkg::reg_sel_e sel,
                           input logic [htdu_pkg::ByteW-1:0] data);
    send_cmd(htdu_pkg::OP_WRITE, sel, data, htdu_pkg::ByteW'($urandom), 1'($urandom));
  endtask

  task automatic tick(input logic [htdu_pkg::ByteW-1:0] cycles, input logic step);
    send_cmd(htdu_pkg::OP_TICK, htdu_pkg::reg_sel_e'($urandom),
             htdu_pkg::ByteW'($urandom), cycles, step);
  endtask

  // One random command, weighted towards ticks. Counter and modulo writes
  // lean towards the top of the range so that overflows come often; control
  // writes stay rare so the prescale count gets time to build up.
  task automatic random_cmd();
    int unsigned                roll;
    int unsigned                pick;
    logic [htdu_pkg::ByteW-1:0] cycles;
    logic [htdu_pkg::ByteW-1:0] data;
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (roll < 55) begin
      if (pick < 60)      cycles = htdu_pkg::ByteW'($urandom);
      else if (pick < 85) cycles = htdu_pkg::ByteW'($urandom_range(0, 20));
      else                cycles = htdu_pkg::ByteW'($urandom_range(240, 255));
      tick(cycles, 1'($urandom));
    end else if (roll < 75) begin
      read_reg(htdu_pkg::reg_sel_e'($urandom));
    end else if (roll < 96) begin
      data = htdu_pkg::ByteW'($urandom);
      if (pick < 30) begin
        write_reg(htdu_pkg::REG_DIVIDER, data);
      end else if (pick < 63) begin
        if ($urandom_range(0, 1)) data = htdu_pkg::ByteW'($urandom_range(248, 255));
        write_reg(htdu_pkg::REG_COUNTER, data);
      end else if (pick < 95) begin
        if ($urandom_range(0, 1)) data = htdu_pkg::ByteW'($urandom_range(224, 255));
        write_reg(htdu_pkg::REG_MODULO, data);
      end else begin
        write_reg(htdu_pkg::REG_CONTROL, data);
      end
    end else begin
      send_cmd(OpNop, 2'($urandom), htdu_pkg::ByteW'($urandom),
               htdu_pkg::ByteW'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int unsigned                sent;
    int unsigned                phase;
    logic [htdu_pkg::ByteW-1:0] ctl_byte;

    // Drive every input to a known value before anything else happens
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    opcode_i         = htdu_pkg::OP_READ;
    reg_select_i     = htdu_pkg::REG_DIVIDER;
    write_data_i     = '0;
    elapsed_cycles_i = '0;
    divider_step_i   = 1'b0;
    idle_cycles      = 0;
    src_gaps_en      = 1'b0;
    sink_stalls_en   = 1'b0;
    scoreboard_h     = new();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: registers straight out of reset, the overflow and reload
    // path, divider clear on a write of any value, control masking to three bits
    read_reg(htdu_pkg::REG_DIVIDER);
    read_reg(htdu_pkg::REG_CONTROL);
    write_reg(htdu_pkg::REG_COUNTER, 8'hFF);
    write_reg(htdu_pkg::REG_MODULO, 8'hA5);
    write_reg(htdu_pkg::REG_CONTROL, 8'hFF);
    read_reg(htdu_pkg::REG_CONTROL);
    tick(8'hFF, 1'b1);
    tick(8'h01, 1'b0);
    read_reg(htdu_pkg::REG_COUNTER);
    read_reg(htdu_pkg::REG_DIVIDER);
    write_reg(htdu_pkg::REG_DIVIDER, 8'hFF);
    read_reg(htdu_pkg::REG_DIVIDER);
    // Disabled timer at the shortest period: only one period comes off per
    // tick, so the prescale count climbs until it saturates at the top
    write_reg(htdu_pkg::REG_CONTROL, 8'h01);
    repeat (10) tick(8'hFF, 1'b1);
    read_reg(htdu_pkg::REG_COUNTER);
    send_cmd(OpNop, 2'b11, 8'hFF, 8'hFF, 1'b1);
    write_reg(htdu_pkg::REG_COUNTER, 8'h00);
    read_reg(htdu_pkg::REG_MODULO);

    // Random: each phase sets up a period and a modulo, then streams mixed
    // commands; gaps and stalls are switched per phase, mostly on
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      src_gaps_en    = ($urandom_range(0, 3) != 0);
      sink_stalls_en = ($urandom_range(0, 3) != 0);
      ctl_byte       = htdu_pkg::ByteW'($urandom);
      ctl_byte[1:0]  = phase[1:0];
      ctl_byte[htdu_pkg::CtrlEnableBit] = ($urandom_range(0, 4) != 0);
      write_reg(htdu_pkg::REG_CONTROL, ctl_byte);
      write_reg(htdu_pkg::REG_MODULO, htdu_pkg::ByteW'($urandom));
      sent = sent + 2;
      for (int unsigned i = 0; i < PhaseLen && sent < RandomItems; i++) begin
        random_cmd();
        sent = sent + 1;
      end
      phase = phase + 1;
    end

    // Drop valid, wait for every owed result, then give the pipe time to
    // show any stray extra result
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (scoreboard_h.owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d commands (%0d ticks) over %0d random phases, %0d counter overflows.",
             scoreboard_h.commands, scoreboard_h.ticks, phase, scoreboard_h.irqs);
    $display("Mismatches found: %0d", scoreboard_h.errors);
    if (scoreboard_h.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
